// ===== design/fftw_pkg.sv =====
`default_nettype none

package fftw_pkg;

    // One input word: a complex time-domain sample.
    typedef struct packed {
        logic signed [23:0] sample_real;
        logic signed [23:0] sample_imag;
    } t_in_word;

    // One output word: a transform bin.
    typedef struct packed {
        logic signed [31:0] bin_real;
        logic signed [31:0] bin_imag;
        logic [5:0]         bin_index;
        logic               last_bin;
    } t_out_word;

    // Stored complex data word.
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cplx;

    // Entry of the queue between the front and the back.
    typedef struct packed {
        t_in_word sample;
        logic     last;
        logic     inverse;
        logic     window;
    } t_cmd;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b1;

    localparam int Q_DEPTH = 4;

    // Fixed-point constants used to build the twiddle and window tables.
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] K054_Q30    = 64'd579820585;
    localparam logic [63:0] K046_Q30    = 64'd493921239;

endpackage

`default_nettype wire

// ===== design/radix2_fft_with_hamming_window.sv =====
`default_nettype none

// Radix-2 decimation-in-time FFT with optional Hamming window.
// Input channel (i_in_valid / o_in_stall / i_in_word): one complex sample per
// word; N_POINTS words make a frame. A four-entry queue takes the samples while
// the transform engine is busy, and o_in_stall rises only when it is full.
// Output channel (o_out_valid / i_out_stall / o_out_word): N_POINTS bins in
// natural order, last_bin set on the final one. A stalled output word holds.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_data): index 0 selects the
// inverse transform, index 1 enables the window; both are sampled with the
// last sample of a frame.
// Per frame, with one store (one read and one write port) and one butterfly
// unit, the back end loads the samples, windows them if enabled in a forward
// transform, swaps the bit-reversed pairs (reading both entries, then writing
// both), runs the N/2*log2(N) butterflies, scales an inverse result and reads
// the bins out. Window and scaling never run together; the butterfly unit
// sets most of a frame's time.
// Reset (synchronous, active low) empties the queue, clears the registers
// and starts a new frame.
module radix2_fft_with_hamming_window #(
    parameter int N_POINTS     = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire fftw_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fftw_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_cfg_we,
    input  wire logic [fftw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fftw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fftw_pkg::t_cmd_chan chan;
    logic                cmd_pop;

    fftw_front #(
        .N_POINTS(N_POINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_chan     (chan),
        .i_cmd_pop  (cmd_pop)
    );

    fftw_back #(
        .N_POINTS    (N_POINTS),
        .TWIDDLE_BITS(TWIDDLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_chan     (chan),
        .o_cmd_pop  (cmd_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// ===== design/fftw_ram.sv =====
`default_nettype none

module fftw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/fftw_front.sv =====
`default_nettype none

module fftw_front #(
    parameter int N_POINTS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire fftw_pkg::t_in_word                 i_in_word,
    input  wire logic                               i_cfg_we,
    input  wire logic [fftw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fftw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output fftw_pkg::t_cmd_chan                     o_chan,
    input  wire logic                               i_cmd_pop
);

    localparam int LG  = $clog2(N_POINTS);
    localparam int QAW = $clog2(fftw_pkg::Q_DEPTH);

    fftw_pkg::t_cmd r_q [fftw_pkg::Q_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic [LG-1:0]  r_lc;
    logic           r_inverse, r_window;
    logic           push;

    assign o_in_stall   = (r_cnt == (QAW+1)'(fftw_pkg::Q_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_chan.valid = (r_cnt != '0);
    assign o_chan.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].sample  <= i_in_word;
            r_q[r_wp].last    <= (r_lc == LG'(N_POINTS - 1));
            r_q[r_wp].inverse <= r_inverse;
            r_q[r_wp].window  <= r_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_lc      <= '0;
            r_inverse <= 1'b0;
            r_window  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
                r_lc <= r_lc + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(i_cmd_pop);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fftw_pkg::CFG_INVERSE: r_inverse <= i_cfg_data[0];
                    fftw_pkg::CFG_WINDOW:  r_window  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_cnt != '0) else $error("queue popped while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(fftw_pkg::Q_DEPTH)) else $error("queue overfilled");
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_lc == LG'(N_POINTS - 1) |=> r_lc == '0)
        else $error("frame counter did not wrap");

endmodule

`default_nettype wire

// ===== design/fftw_back.sv =====
`default_nettype none

module fftw_back #(
    parameter int N_POINTS     = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fftw_pkg::t_cmd_chan i_chan,
    output logic                     o_cmd_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output fftw_pkg::t_out_word      o_out_word
);

    localparam int LG   = $clog2(N_POINTS);
    localparam int SW   = (LG > 1) ? $clog2(LG) : 1;
    localparam int TF   = TWIDDLE_BITS - 1;
    localparam int RS   = 31 - TWIDDLE_BITS;
    localparam int PW   = 32 + TWIDDLE_BITS;
    localparam int SUMW = PW + 2;
    localparam int DW   = $bits(fftw_pkg::t_cplx);
    localparam int HALF_N = N_POINTS / 2;

    localparam logic signed [PW:0]     HALF = (PW+1)'(1) << (TF - 1);
    localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-32){1'b0}}, 32'h7fffffff};
    localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-32){1'b1}}, 32'h80000000};

    typedef logic signed [TWIDDLE_BITS-1:0] t_rom [HALF_N];

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_WIN   = 6'b000010,
        S_REV   = 6'b000100,
        S_BFLY  = 6'b001000,
        S_SCALE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // cos(2*pi*num/den) in Q30 by a truncated Taylor series; den is N or N-1.
    function automatic logic signed [63:0] cos_q30(input logic [63:0] num,
                                                   input logic use_nm1);
        logic [63:0]        th, x2, term;
        logic signed [63:0] sum;
        logic               neg;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        neg  = 1'b0;
        if (use_nm1) begin
            th = (64'd2 * fftw_pkg::PI_Q30 * num) / 64'(N_POINTS - 1);
        end else begin
            th = (64'd2 * fftw_pkg::PI_Q30 * num) / 64'(N_POINTS);
        end
        if (th > fftw_pkg::PI_Q30) th = fftw_pkg::PI_Q30;
        if (th > fftw_pkg::HALF_PI_Q30) begin
            th  = fftw_pkg::PI_Q30 - th;
            neg = 1'b1;
        end
        x2 = (th * th) >> 30;
        for (int n = 1; n < 24; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) sum = sum - $signed(term);
            else            sum = sum + $signed(term);
        end
        return neg ? -sum : sum;
    endfunction

    function automatic logic signed [TWIDDLE_BITS-1:0] to_rom(input logic signed [63:0] v);
        logic [63:0] mag, r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (RS - 1))) >> RS;
        if (r > ((64'd1 << TF) - 64'd1)) r = (64'd1 << TF) - 64'd1;
        return (v < 0) ? -$signed(TWIDDLE_BITS'(r)) : $signed(TWIDDLE_BITS'(r));
    endfunction

    function automatic t_rom build_cos();
        t_rom t;
        for (int k = 0; k < HALF_N; k++) begin
            t[k] = to_rom(cos_q30(64'(k), 1'b0));
        end
        return t;
    endfunction

    function automatic t_rom build_sin();
        t_rom t;
        int   d;
        for (int k = 0; k < HALF_N; k++) begin
            d    = (k > N_POINTS / 4) ? k - N_POINTS / 4 : N_POINTS / 4 - k;
            t[k] = to_rom(cos_q30(64'(d), 1'b0));
        end
        return t;
    endfunction

    function automatic t_rom build_win();
        t_rom               t;
        logic signed [63:0] c;
        logic [63:0]        pm, p;
        for (int k = 0; k < HALF_N; k++) begin
            c    = cos_q30(64'(k), 1'b1);
            pm   = fftw_pkg::K046_Q30 * ((c < 0) ? 64'(-c) : 64'(c));
            p    = (pm + (64'd1 << 29)) >> 30;
            t[k] = to_rom($signed(fftw_pkg::K054_Q30) - ((c < 0) ? -$signed(p) : $signed(p)));
        end
        return t;
    endfunction

    localparam t_rom COS_ROM = build_cos();
    localparam t_rom SIN_ROM = build_sin();
    localparam t_rom WIN_ROM = build_win();

    function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] x);
        if (x > SMAX) return 32'sh7fffffff;
        if (x < SMIN) return 32'sh80000000;
        return x[31:0];
    endfunction

    t_state          r_state, n_state;
    logic [2:0]      r_ph, n_ph;
    logic [LG-1:0]   r_idx, n_idx;
    logic [SW-1:0]   r_stg, n_stg;
    logic            r_inv, r_win;
    logic            r_ovalid, n_ovalid;

    fftw_pkg::t_cplx             r_x, r_a, rd;
    logic signed [TWIDDLE_BITS-1:0] r_wr, r_wi, r_wn;
    logic signed [PW-1:0]        r_p1, r_p2, r_p3, r_p4;
    logic signed [PW:0]          r_tr, r_ti;
    fftw_pkg::t_out_word         r_out;

    logic            ram_we, ram_re;
    logic [LG-1:0]   ram_waddr, ram_raddr;
    fftw_pkg::t_cplx ram_wdata;
    logic [DW-1:0]   ram_rdata;

    logic [LG-1:0]   bw, lo_mask, bi, bm, rev, win_idx;
    logic [LG-2:0]   kk;
    logic [SW-1:0]   tw_sh;
    logic            out_load, out_take;
    logic signed [PW:0] win_rnd, d_re, d_im;

    assign rd = fftw_pkg::t_cplx'(ram_rdata);

    // Butterfly addressing for stage r_stg and butterfly number r_idx.
    always_comb begin
        bw      = {1'b0, r_idx[LG-2:0]};
        lo_mask = (LG'(1) << r_stg) - LG'(1);
        bi      = ((bw >> r_stg) << (r_stg + (SW+1)'(1))) | (bw & lo_mask);
        bm      = bi | (LG'(1) << r_stg);
        tw_sh   = SW'(LG - 1) - r_stg;
        kk      = (r_idx[LG-2:0] & lo_mask[LG-2:0]) << tw_sh;
        for (int b = 0; b < LG; b++) begin
            rev[LG-1-b] = r_idx[b];
        end
        win_idx = {1'b0, (r_idx[LG-1] ? ~r_idx[LG-2:0] : r_idx[LG-2:0])};
        win_rnd = ($signed({r_p1[PW-1], r_p1}) + HALF) >>> TF;
        d_re    = $signed({r_p1[PW-1], r_p1}) - $signed({r_p2[PW-1], r_p2});
        d_im    = $signed({r_p3[PW-1], r_p3}) + $signed({r_p4[PW-1], r_p4});
    end

    assign out_take = r_ovalid && !i_out_stall;
    assign o_cmd_pop = (r_state == S_LOAD) && i_chan.valid;

    always_comb begin
        n_state   = r_state;
        n_ph      = r_ph;
        n_idx     = r_idx;
        n_stg     = r_stg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_idx;
        ram_raddr = r_idx;
        ram_wdata = rd;
        out_load  = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (i_chan.valid) begin
                    ram_we       = 1'b1;
                    ram_wdata.re = {{8{i_chan.cmd.sample.sample_real[23]}},
                                    i_chan.cmd.sample.sample_real};
                    ram_wdata.im = {{8{i_chan.cmd.sample.sample_imag[23]}},
                                    i_chan.cmd.sample.sample_imag};
                    n_idx        = r_idx + 1'b1;
                    if (i_chan.cmd.last) begin
                        n_idx   = '0;
                        n_ph    = '0;
                        n_state = (i_chan.cmd.window && !i_chan.cmd.inverse) ? S_WIN : S_REV;
                    end
                end
            end
            S_WIN: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 3'd0) ram_re = 1'b1;
                if (r_ph == 3'd3) begin
                    ram_we       = 1'b1;
                    ram_wdata.re = sat32({win_rnd[PW], win_rnd});
                    ram_wdata.im = r_x.im;
                    n_ph         = '0;
                    n_idx        = r_idx + 1'b1;
                    if (r_idx == LG'(N_POINTS - 1)) n_state = S_REV;
                end
            end
            S_REV: begin
                n_ph = r_ph + 1'b1;
                priority case (r_ph)
                    3'd0: begin
                        if (r_idx < rev) begin
                            ram_re = 1'b1;
                        end else begin
                            n_ph  = '0;
                            n_idx = r_idx + 1'b1;
                            if (r_idx == LG'(N_POINTS - 1)) begin
                                n_state = S_BFLY;
                                n_stg   = '0;
                            end
                        end
                    end
                    3'd1: begin
                        ram_re    = 1'b1;
                        ram_raddr = rev;
                    end
                    3'd2: begin
                        ram_we = 1'b1;
                    end
                    default: begin
                        ram_we    = 1'b1;
                        ram_waddr = rev;
                        ram_wdata = r_a;
                        n_ph      = '0;
                        n_idx     = r_idx + 1'b1;
                        if (r_idx == LG'(N_POINTS - 1)) begin
                            n_state = S_BFLY;
                            n_stg   = '0;
                        end
                    end
                endcase
            end
            S_BFLY: begin
                n_ph = r_ph + 1'b1;
                priority case (r_ph)
                    3'd0: begin
                        ram_re    = 1'b1;
                        ram_raddr = bm;
                    end
                    3'd1: begin
                        ram_re    = 1'b1;
                        ram_raddr = bi;
                    end
                    3'd2, 3'd3: ;
                    3'd4: begin
                        ram_we       = 1'b1;
                        ram_waddr    = bi;
                        ram_wdata.re = sat32({{(SUMW-32){r_a.re[31]}}, r_a.re}
                                             + {r_tr[PW], r_tr});
                        ram_wdata.im = sat32({{(SUMW-32){r_a.im[31]}}, r_a.im}
                                             + {r_ti[PW], r_ti});
                    end
                    default: begin
                        ram_we       = 1'b1;
                        ram_waddr    = bm;
                        ram_wdata.re = sat32({{(SUMW-32){r_a.re[31]}}, r_a.re}
                                             - {r_tr[PW], r_tr});
                        ram_wdata.im = sat32({{(SUMW-32){r_a.im[31]}}, r_a.im}
                                             - {r_ti[PW], r_ti});
                        n_ph         = '0;
                        n_idx        = r_idx + 1'b1;
                        if (r_idx == LG'(HALF_N - 1)) begin
                            n_idx = '0;
                            n_stg = r_stg + 1'b1;
                            if (r_stg == SW'(LG - 1)) begin
                                n_state = r_inv ? S_SCALE : S_OUT;
                            end
                        end
                    end
                endcase
            end
            S_SCALE: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 3'd0) begin
                    ram_re = 1'b1;
                end else begin
                    ram_we       = 1'b1;
                    ram_wdata.re = rd.re >>> LG;
                    ram_wdata.im = rd.im >>> LG;
                    n_ph         = '0;
                    n_idx        = r_idx + 1'b1;
                    if (r_idx == LG'(N_POINTS - 1)) n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (r_ph == 3'd0) begin
                    ram_re = 1'b1;
                    n_ph   = 3'd1;
                end else if (!r_ovalid || out_take) begin
                    out_load = 1'b1;
                    n_ph     = '0;
                    n_idx    = r_idx + 1'b1;
                    if (r_idx == LG'(N_POINTS - 1)) n_state = S_LOAD;
                end
            end
            default: ;
        endcase
        n_ovalid = out_load ? 1'b1 : (out_take ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ph     <= '0;
            r_idx    <= '0;
            r_stg    <= '0;
            r_inv    <= 1'b0;
            r_win    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_idx    <= n_idx;
            r_stg    <= n_stg;
            r_ovalid <= n_ovalid;
            if (o_cmd_pop && i_chan.cmd.last) begin
                r_inv <= i_chan.cmd.inverse;
                r_win <= i_chan.cmd.window;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WIN) begin
            if (r_ph == 3'd1) begin
                r_x  <= rd;
                r_wn <= WIN_ROM[win_idx[LG-2:0]];
            end
            if (r_ph == 3'd2) r_p1 <= r_x.re * r_wn;
        end
        if (r_state == S_REV && r_ph == 3'd1) r_a <= rd;
        if (r_state == S_BFLY) begin
            if (r_ph == 3'd1) begin
                r_x  <= rd;
                r_wr <= COS_ROM[kk];
                r_wi <= r_inv ? SIN_ROM[kk] : -SIN_ROM[kk];
            end
            if (r_ph == 3'd2) begin
                r_a  <= rd;
                r_p1 <= r_x.re * r_wr;
                r_p2 <= r_x.im * r_wi;
                r_p3 <= r_x.im * r_wr;
                r_p4 <= r_x.re * r_wi;
            end
            if (r_ph == 3'd3) begin
                r_tr <= (d_re + HALF) >>> TF;
                r_ti <= (d_im + HALF) >>> TF;
            end
        end
        if (out_load) begin
            r_out.bin_real  <= rd.re;
            r_out.bin_imag  <= rd.im;
            r_out.bin_index <= 6'(r_idx);
            r_out.last_bin  <= (r_idx == LG'(N_POINTS - 1));
        end
    end

    fftw_ram #(
        .WIDTH(DW),
        .DEPTH(N_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    a_last_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_idx == LG'(N_POINTS - 1) |=> r_state == S_LOAD)
        else $error("back end did not return to loading after the last bin");
    a_no_write_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> !ram_we) else $error("store written during output");
    a_rev_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REV && r_ph != 3'd0 |-> r_idx < rev)
        else $error("swap started on a pair already swapped");
    a_win_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WIN |-> r_win && !r_inv) else $error("window pass in wrong mode");
    a_load_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> r_ph == 3'd0) else $error("stale step count in load");

endmodule

`default_nettype wire

// ===== sim/fft_bin_checker.sv =====
module fft_bin_checker #(
    parameter int N_POINTS     = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  wire fftw_pkg::t_in_word               i_in_word,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire fftw_pkg::t_out_word              i_out_word,
    input  wire logic                             i_cfg_we,
    input  wire logic [fftw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fftw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                    o_errors,
    output int                                    o_pending
);

    localparam int FRAC   = TWIDDLE_BITS - 1;
    localparam int STAGES = $clog2(N_POINTS);

    longint              cos_rom [N_POINTS/2];
    longint              sin_rom [N_POINTS/2];
    longint              hamming_rom [N_POINTS/2];
    longint              frame_re [N_POINTS];
    longint              frame_im [N_POINTS];
    int                  samples_loaded;
    logic                inverse_sel;
    logic                window_sel;
    fftw_pkg::t_out_word expected_bins [$];

    // Cosine of 2*pi*num/den in Q30, truncated Taylor series folded to pi/2.
    function automatic longint cosine_q30(longint unsigned num, longint unsigned den);
        longint unsigned th, x2, term;
        longint          sum;
        bit              neg;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        neg  = 1'b0;
        th   = (2 * fftw_pkg::PI_Q30 * num) / den;
        if (th > fftw_pkg::PI_Q30) th = fftw_pkg::PI_Q30;
        if (th > fftw_pkg::HALF_PI_Q30) begin
            th  = fftw_pkg::PI_Q30 - th;
            neg = 1'b1;
        end
        x2 = (th * th) >> 30;
        for (int n = 1; n < 24 && term != 0; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return neg ? -sum : sum;
    endfunction

    // Q30 to the table format: round half away from zero, clip to the top code.
    function automatic longint rom_code(longint v);
        longint mag, r;
        mag = (v < 0) ? -v : v;
        r   = (mag + (64'sd1 << (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
        if (r > (64'sd1 << FRAC) - 1) r = (64'sd1 << FRAC) - 1;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint scale_round(longint x);
        return (x + (64'sd1 << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Transforms the loaded frame in place with the current register settings.
    function automatic void transform_frame();
        int     r, m, k, stride;
        longint wr, wi, tr, ti, ar, ai, t;
        if (!inverse_sel && window_sel) begin
            for (int i = 0; i < N_POINTS; i++) begin
                k = (i < N_POINTS / 2) ? i : N_POINTS - 1 - i;
                frame_re[i] = clip32(scale_round(frame_re[i] * hamming_rom[k]));
            end
        end
        for (int i = 0; i < N_POINTS; i++) begin
            r = 0;
            for (int b = 0; b < STAGES; b++) r = (r << 1) | ((i >> b) & 1);
            if (i < r) begin
                t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
                t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
            end
        end
        for (int half = 1; half < N_POINTS; half = half * 2) begin
            stride = N_POINTS / (2 * half);
            for (int j = 0; j < half; j++) begin
                k  = (j * stride) % (N_POINTS / 2);
                wr = cos_rom[k];
                wi = inverse_sel ? sin_rom[k] : -sin_rom[k];
                for (int i = j; i + half < N_POINTS; i += 2 * half) begin
                    m  = i + half;
                    tr = scale_round(wr * frame_re[m] - wi * frame_im[m]);
                    ti = scale_round(wr * frame_im[m] + wi * frame_re[m]);
                    ar = frame_re[i];
                    ai = frame_im[i];
                    frame_re[m] = clip32(ar - tr);
                    frame_im[m] = clip32(ai - ti);
                    frame_re[i] = clip32(ar + tr);
                    frame_im[i] = clip32(ai + ti);
                end
            end
        end
        if (inverse_sel) begin
            for (int i = 0; i < N_POINTS; i++) begin
                frame_re[i] = frame_re[i] >>> STAGES;
                frame_im[i] = frame_im[i] >>> STAGES;
            end
        end
    endfunction

    initial begin
        longint c, p;
        int     d;
        for (int k = 0; k < N_POINTS / 2; k++) begin
            d = (k > N_POINTS / 4) ? k - N_POINTS / 4 : N_POINTS / 4 - k;
            c = cosine_q30(k, N_POINTS - 1);
            p = (fftw_pkg::K046_Q30 * ((c < 0) ? -c : c) + (64'sd1 << 29)) >>> 30;
            cos_rom[k]     = rom_code(cosine_q30(k, N_POINTS));
            sin_rom[k]     = rom_code(cosine_q30(d, N_POINTS));
            hamming_rom[k] = rom_code(fftw_pkg::K054_Q30 - ((c < 0) ? -p : p));
        end
    end

    always @(posedge i_clk) begin
        fftw_pkg::t_out_word bin;
        if (!i_rst_n) begin
            samples_loaded <= 0;
            inverse_sel    <= 1'b0;
            window_sel     <= 1'b0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == fftw_pkg::CFG_INVERSE) inverse_sel <= i_cfg_data[0];
                if (i_cfg_index == fftw_pkg::CFG_WINDOW) window_sel <= i_cfg_data[0];
            end
            if (i_in_valid && !i_in_stall) begin
                frame_re[samples_loaded] = longint'(i_in_word.sample_real);
                frame_im[samples_loaded] = longint'(i_in_word.sample_imag);
                if (samples_loaded == N_POINTS - 1) begin
                    samples_loaded <= 0;
                    transform_frame();
                    for (int k = 0; k < N_POINTS; k++) begin
                        bin.bin_real  = frame_re[k][31:0];
                        bin.bin_imag  = frame_im[k][31:0];
                        bin.bin_index = k[5:0];
                        bin.last_bin  = (k == N_POINTS - 1);
                        expected_bins.push_back(bin);
                    end
                end else begin
                    samples_loaded <= samples_loaded + 1;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bins.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("unexpected bin word %h", i_out_word);
                end else begin
                    bin = expected_bins.pop_front();
                    if (i_out_word !== bin) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display({"bin %0d: expected re %0d im %0d idx %0d last %0b,",
                                      " got re %0d im %0d idx %0d last %0b"},
                                bin.bin_index, bin.bin_real, bin.bin_imag, bin.bin_index,
                                bin.last_bin, i_out_word.bin_real, i_out_word.bin_imag,
                                i_out_word.bin_index, i_out_word.last_bin);
                    end
                end
            end
        end
        o_pending = expected_bins.size();
    end

endmodule

// ===== sim/tb_radix2_fft_with_hamming_window.sv =====
module tb_radix2_fft_with_hamming_window;

    localparam int N_POINTS = 64;
    localparam int IDLE_PCT = 31;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            in_valid;
    logic                            in_stall;
    fftw_pkg::t_in_word              in_word;
    logic                            out_valid;
    logic                            out_stall;
    fftw_pkg::t_out_word             out_word;
    logic                            cfg_we;
    logic [fftw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fftw_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              errors;
    int                              pending;
    bit                              steady_in;
    bit                              steady_out;

    radix2_fft_with_hamming_window #(.N_POINTS(N_POINTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    fft_bin_checker #(.N_POINTS(N_POINTS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(negedge i_clk)
        out_stall <= !steady_out && ($urandom_range(0, 99) < IDLE_PCT);

    // Sends one sample word, idling at random first, and waits for acceptance.
    task automatic send_sample(input logic [23:0] re, input logic [23:0] im);
        while (!steady_in && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{sample_real: re, sample_imag: im};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [fftw_pkg::CFG_IDX_W-1:0] idx, input logic value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Lets all bins of the previous frames drain before touching registers.
    task automatic drain_frames();
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [23:0] random_part();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 511)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_frame(input int first);
        for (int i = first; i < N_POINTS; i++) send_sample(random_part(), random_part());
        in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_we     = 1'b0;
        cfg_index  = fftw_pkg::CFG_INVERSE;
        cfg_data   = 1'b0;
        steady_in  = 1'b0;
        steady_out = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes and plain bit patterns open the first frame.
        write_reg(fftw_pkg::CFG_INVERSE, 1'b0);
        write_reg(fftw_pkg::CFG_WINDOW, 1'b0);
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'h555555, 24'hAAAAAA);
        send_sample(24'hAAAAAA, 24'h555555);
        send_sample(24'h000001, 24'hFFFFFF);
        send_sample(24'hFFFFFF, 24'h000001);
        send_sample(24'h7FFFFF, 24'h800000);
        random_frame(8);

        // Windowed forward frame with the input side never idling.
        drain_frames();
        write_reg(fftw_pkg::CFG_WINDOW, 1'b1);
        steady_in = 1'b1;
        random_frame(0);
        steady_in = 1'b0;

        // Inverse with window requested: the window must be skipped.
        drain_frames();
        write_reg(fftw_pkg::CFG_INVERSE, 1'b1);
        steady_out = 1'b1;
        random_frame(0);
        in_valid <= 1'b0;

        drain_frames();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== radix2_fft_with_hamming_window.f =====
design/fftw_pkg.sv
design/fftw_ram.sv
design/fftw_front.sv
design/fftw_back.sv
design/radix2_fft_with_hamming_window.sv
sim/fft_bin_checker.sv
sim/tb_radix2_fft_with_hamming_window.sv
